// File: design/assert_macros.svh
// Assertion macros used by the checker file warhd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/warhd_pkg.sv
package warhd_pkg;

	// Number of tracked addresses and the width of a slot index.
	localparam int TRACK_ENTRIES = 64;
	localparam int SLOT_W = (TRACK_ENTRIES > 1) ? $clog2(TRACK_ENTRIES) : 1;

	// Field widths.
	localparam int ADDR_W = 32;
	localparam int DATA_W = 32;
	localparam int REQ_W = 2;
	localparam int CFG_INDEX_W = 2;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_VOLATILE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOLATILE_BASE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_VOLATILE_LENGTH = 2'd2;

	// One result item.
	typedef struct packed {
		logic              hazard_found;
		logic [ADDR_W-1:0] hazard_address;
		logic [DATA_W-1:0] first_read_pc;
		logic [DATA_W-1:0] first_read_value;
		logic [DATA_W-1:0] offending_write_pc;
		logic [DATA_W-1:0] offending_write_value;
		logic              access_skipped;
		logic              table_full;
	} result_t;

endpackage

// File: design/warhd_if.sv
// Channel carrying one memory access per transaction.
interface warhd_access_if;
	logic                              valid;
	logic                              ready;
	logic [warhd_pkg::REQ_W-1:0]       req_type;
	logic [warhd_pkg::ADDR_W-1:0]      access_address;
	logic [warhd_pkg::DATA_W-1:0]      access_value;
	logic [warhd_pkg::DATA_W-1:0]      access_pc;

	modport source (output valid, req_type, access_address, access_value, access_pc,
		input ready);
	modport sink (input valid, req_type, access_address, access_value, access_pc,
		output ready);
endinterface

// Channel carrying one detector result per transaction.
interface warhd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              hazard_found;
	logic [warhd_pkg::ADDR_W-1:0]      hazard_address;
	logic [warhd_pkg::DATA_W-1:0]      first_read_pc;
	logic [warhd_pkg::DATA_W-1:0]      first_read_value;
	logic [warhd_pkg::DATA_W-1:0]      offending_write_pc;
	logic [warhd_pkg::DATA_W-1:0]      offending_write_value;
	logic                              access_skipped;
	logic                              table_full;

	modport source (output valid, hazard_found, hazard_address, first_read_pc,
		first_read_value, offending_write_pc, offending_write_value, access_skipped,
		table_full, input ready);
	modport sink (input valid, hazard_found, hazard_address, first_read_pc,
		first_read_value, offending_write_pc, offending_write_value, access_skipped,
		table_full, output ready);
endinterface

// Configuration write channel.
interface warhd_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [warhd_pkg::CFG_INDEX_W-1:0] index;
	logic [warhd_pkg::DATA_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/write_after_read_hazard_detector.sv
// Write-after-read hazard detector for nonvolatile memory. Each access
// transaction (read, write or clear) produces exactly one result transaction.
// The block takes one access per cycle while the result register is free or being
// drained. A result is offered once its access has passed the input register stage
// and is held in an output register until taken, while the next access is already
// being accepted. The critical path is the parallel compare of the access address
// against all tracked slots plus the lowest-free-slot search, both combinational.
// Reset empties the table at once; a clear request empties it again.
// Configuration writes are always accepted and take effect on the next access.
module write_after_read_hazard_detector (
	input  logic                  clk,
	input  logic                  arst_n,
	warhd_cfg_if.sink             cfg,
	warhd_access_if.sink          access,
	warhd_result_if.source        result
);

	localparam int N = warhd_pkg::TRACK_ENTRIES;

	// Configuration registers.
	logic                          ignore_volatile_q;
	logic [warhd_pkg::ADDR_W-1:0]  volatile_base_q;
	logic [warhd_pkg::ADDR_W-1:0]  volatile_length_q;

	// Input register stage.
	logic                          valid_s1;
	logic [warhd_pkg::REQ_W-1:0]   req_s1;
	logic [warhd_pkg::ADDR_W-1:0]  addr_s1;
	logic [warhd_pkg::DATA_W-1:0]  value_s1;
	logic [warhd_pkg::DATA_W-1:0]  pc_s1;

	// Tracking table.
	logic [N-1:0]                  slot_valid_q;
	logic [N-1:0]                  slot_read_seen_q;
	logic [N-1:0]                  slot_safely_written_q;
	logic [warhd_pkg::ADDR_W-1:0]  slot_address_q    [N];
	logic [warhd_pkg::DATA_W-1:0]  slot_read_pc_q    [N];
	logic [warhd_pkg::DATA_W-1:0]  slot_read_value_q [N];

	// Result register.
	logic                          result_valid_q;
	warhd_pkg::result_t            result_q;

	// Lookup and decision signals.
	logic                          advance;
	logic [N-1:0]                  match_oh;
	logic [N-1:0]                  free_vec;
	logic [N-1:0]                  alloc_oh;
	logic                          hit;
	logic                          hit_read_seen;
	logic                          hit_safely_written;
	logic [warhd_pkg::DATA_W-1:0]  hit_read_pc;
	logic [warhd_pkg::DATA_W-1:0]  hit_read_value;
	logic [warhd_pkg::ADDR_W:0]    volatile_end;
	logic                          in_volatile;
	logic                          do_clear;
	logic                          do_alloc;
	logic                          do_set_read;
	logic                          do_set_safe;
	warhd_pkg::result_t            result_d;

	// Configuration writes; indexes past the register list are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_volatile_q <= 1'b1;
			volatile_base_q   <= '0;
			volatile_length_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				warhd_pkg::CFG_IGNORE_VOLATILE: ignore_volatile_q <= cfg.data[0];
				warhd_pkg::CFG_VOLATILE_BASE:   volatile_base_q   <= cfg.data;
				warhd_pkg::CFG_VOLATILE_LENGTH: volatile_length_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// The decision stage moves when the result register is free or being drained.
	assign advance      = valid_s1 && (!result_valid_q || result.ready);
	assign access.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (access.ready) begin
			valid_s1 <= access.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (access.ready && access.valid) begin
			req_s1   <= access.req_type;
			addr_s1  <= access.access_address;
			value_s1 <= access.access_value;
			pc_s1    <= access.access_pc;
		end
	end

	// Volatile region test with a carry bit on the end address.
	assign volatile_end = {1'b0, volatile_base_q} + {1'b0, volatile_length_q};
	assign in_volatile  = (addr_s1 >= volatile_base_q)
		&& ({1'b0, addr_s1} < volatile_end);

	// Parallel address compare over all slots; at most one slot matches.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match_oh[i] = slot_valid_q[i] && (slot_address_q[i] == addr_s1);
		end
	end

	// One-hot read of the matching slot.
	always_comb begin
		hit_read_seen      = 1'b0;
		hit_safely_written = 1'b0;
		hit_read_pc        = '0;
		hit_read_value     = '0;
		for (int i = 0; i < N; i++) begin
			hit_read_seen      = hit_read_seen | (match_oh[i] & slot_read_seen_q[i]);
			hit_safely_written = hit_safely_written
				| (match_oh[i] & slot_safely_written_q[i]);
			hit_read_pc        = hit_read_pc | ({warhd_pkg::DATA_W{match_oh[i]}}
				& slot_read_pc_q[i]);
			hit_read_value     = hit_read_value | ({warhd_pkg::DATA_W{match_oh[i]}}
				& slot_read_value_q[i]);
		end
	end

	assign hit = |match_oh;

	// Lowest free slot as the lowest set bit of the free vector.
	assign free_vec = ~slot_valid_q;
	assign alloc_oh = free_vec & (~free_vec + N'(1));

	// Decision for the access in the input stage.
	always_comb begin
		result_d    = '0;
		do_clear    = 1'b0;
		do_alloc    = 1'b0;
		do_set_read = 1'b0;
		do_set_safe = 1'b0;
		case (req_s1)
			warhd_pkg::REQ_CLEAR: begin
				do_clear = 1'b1;
			end
			warhd_pkg::REQ_READ, warhd_pkg::REQ_WRITE: begin
				if (ignore_volatile_q && in_volatile) begin
					result_d.access_skipped = 1'b1;
				end else if (!hit) begin
					if (free_vec == '0) begin
						result_d.table_full = 1'b1;
					end else begin
						do_alloc = 1'b1;
					end
				end else if (req_s1 == warhd_pkg::REQ_READ) begin
					do_set_read = !hit_read_seen;
				end else if (!hit_safely_written) begin
					if (hit_read_seen) begin
						result_d.hazard_found          = 1'b1;
						result_d.hazard_address        = addr_s1;
						result_d.first_read_pc         = hit_read_pc;
						result_d.first_read_value      = hit_read_value;
						result_d.offending_write_pc    = pc_s1;
						result_d.offending_write_value = value_s1;
					end else begin
						do_set_safe = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Slot control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (advance) begin
			if (do_clear) begin
				slot_valid_q <= '0;
			end else if (do_alloc) begin
				slot_valid_q <= slot_valid_q | alloc_oh;
			end
		end
	end

	// Slot contents, written on allocation or on a first read or safe write.
	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < N; i++) begin
				if (do_alloc && alloc_oh[i]) begin
					slot_address_q[i] <= addr_s1;
					if (req_s1 == warhd_pkg::REQ_READ) begin
						slot_read_seen_q[i]      <= 1'b1;
						slot_read_pc_q[i]        <= pc_s1;
						slot_read_value_q[i]     <= value_s1;
						slot_safely_written_q[i] <= 1'b0;
					end else begin
						slot_read_seen_q[i]      <= 1'b0;
						slot_read_pc_q[i]        <= '0;
						slot_read_value_q[i]     <= '0;
						slot_safely_written_q[i] <= 1'b1;
					end
				end else if (do_set_read && match_oh[i]) begin
					slot_read_seen_q[i]  <= 1'b1;
					slot_read_pc_q[i]    <= pc_s1;
					slot_read_value_q[i] <= value_s1;
				end else if (do_set_safe && match_oh[i]) begin
					slot_safely_written_q[i] <= 1'b1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result.valid                 = result_valid_q;
	assign result.hazard_found          = result_q.hazard_found;
	assign result.hazard_address        = result_q.hazard_address;
	assign result.first_read_pc         = result_q.first_read_pc;
	assign result.first_read_value      = result_q.first_read_value;
	assign result.offending_write_pc    = result_q.offending_write_pc;
	assign result.offending_write_value = result_q.offending_write_value;
	assign result.access_skipped        = result_q.access_skipped;
	assign result.table_full            = result_q.table_full;

endmodule

// File: design/warhd_checker.sv
`include "assert_macros.svh"

// Port-level checks on the detector's result channel.
module warhd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         hazard_found,
	input logic [warhd_pkg::ADDR_W-1:0] hazard_address,
	input logic [warhd_pkg::DATA_W-1:0] first_read_pc,
	input logic [warhd_pkg::DATA_W-1:0] offending_write_pc,
	input logic                         access_skipped,
	input logic                         table_full
);

	logic details_zero;

	// The hazard detail fields all read as zero.
	assign details_zero = (hazard_address == '0) && (first_read_pc == '0)
		&& (offending_write_pc == '0);

	// A hazard is only found for an access that was tracked.
	`ASSERT_IMPLIES(a_hazard_tracked, res_valid && hazard_found, !access_skipped && !table_full)

	// Without a hazard the detail fields read as zero.
	`ASSERT_IMPLIES(a_no_hazard_zero, res_valid && !hazard_found, details_zero)

	// A skipped access never reaches the table.
	`ASSERT_IMPLIES(a_skip_not_full, res_valid && access_skipped, !table_full)

	// A stalled result stays offered with the same hazard flag.
	`ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(hazard_found))

endmodule

bind write_after_read_hazard_detector warhd_checker u_warhd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.res_valid          (result.valid),
	.res_ready          (result.ready),
	.hazard_found       (result.hazard_found),
	.hazard_address     (result.hazard_address),
	.first_read_pc      (result.first_read_pc),
	.offending_write_pc (result.offending_write_pc),
	.access_skipped     (result.access_skipped),
	.table_full         (result.table_full)
);
